>>> sv/lsm_pkg.sv
// lsm_pkg: types, codes and helpers shared by the latency statistics monitor
// no dependencies; imported by lsm_ctrl, lsm_dp and the top level
`timescale 1ns / 1ps
package lsm_pkg;

   localparam int DEF_PATH_COUNT   = 16;
   localparam int DEF_SAMPLE_DEPTH = 64;

   localparam int PADDR_W   = 4;
   localparam int RANK_N_W  = 11;
   localparam int DIV_STEPS = 48;

   localparam logic        RESET_SAMPLING = 1'b1;
   localparam logic [6:0]  RESET_LIMIT    = 7'd64;
   localparam logic [31:0] RESET_SLOW     = 32'd100000;
   localparam logic [31:0] RESET_HOT      = 32'd100000;

   // percentile points, in order median, p95, p99
   localparam logic [6:0] PCT_POINT [3] = '{7'd50, 7'd95, 7'd99};

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } lsm_op_type;

   typedef enum logic [1:0] {
      REG_SAMPLING = 2'd0,
      REG_LIMIT    = 2'd1,
      REG_SLOW     = 2'd2,
      REG_HOT      = 2'd3
   } lsm_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_UPDATE,
      ST_QSTART,
      ST_DIV,
      ST_FLAGS,
      ST_RANK,
      ST_CAND_RD,
      ST_CAND_LATCH,
      ST_SCAN,
      ST_EVAL,
      ST_RESP
   } lsm_state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  path_index;
      logic [31:0] elapsed_ns;
   } lsm_req_type;

   typedef struct packed {
      logic        path_seen;
      logic [31:0] calls;
      logic [47:0] total_ns;
      logic [31:0] shortest_ns;
      logic [31:0] longest_ns;
      logic [31:0] mean_ns;
      logic [31:0] median_ns;
      logic [31:0] p95_ns;
      logic [31:0] p99_ns;
      logic [6:0]  samples_held;
      logic [2:0]  insight_flags;
   } lsm_rsp_type;

   typedef struct packed {
      logic        sampling_enable;
      logic [6:0]  sample_limit;
      logic [31:0] slow_average_ns;
      logic [31:0] hot_call_count;
   } lsm_cfg_type;

   typedef struct packed {
      logic [31:0] calls;
      logic [47:0] total;
      logic [31:0] shortest;
      logic [31:0] longest;
   } lsm_entry_type;

   typedef struct packed {
      logic take_item;
      logic stats_rd;
      logic latch_entry;
      logic do_update;
      logic clear_all;
      logic div_start;
      logic div_step;
      logic flags_calc;
      logic rank_calc;
      logic cand_rd;
      logic cand_latch;
      logic scan_rd;
      logic eval;
      logic load_result;
   } lsm_cmd_type;

   typedef struct packed {
      lsm_op_type op;
      logic       op_valid;
      logic       path_ok;
      logic       div_done;
      logic       rank_last;
      logic       fill_zero;
      logic       scan_done;
      logic       cand_last;
   } lsm_status_type;

   // rank = ceil(pct*n/100) - 1 for n >= 1; divide by 100 via reciprocal 2^26
   function automatic logic [RANK_N_W-1:0] rank_of(input logic [6:0] pct,
                                                    input logic [RANK_N_W-1:0] n);
      logic [17:0] x;
      logic [45:0] prod;
      logic [RANK_N_W-1:0] q;
      x    = 18'(pct) * 18'(n) + 18'd99;
      prod = 46'(x) * 46'd671089;
      q    = prod[26 +: RANK_N_W];
      return (n == '0) ? '0 : q - RANK_N_W'(1);
   endfunction

endpackage

>>> sv/lsm_ram.sv
// lsm_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps
module lsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/lsm_ctrl.sv
// lsm_ctrl: sequencer for record, query and clear items
// depends on lsm_pkg; drives lsm_dp through lsm_cmd_type
`timescale 1ns / 1ps
module lsm_ctrl import lsm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  lsm_status_type status,
   output lsm_cmd_type    cmd
);
   lsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.op_valid && status.op == OP_CLEAR) begin
               cmd.clear_all = 1'b1;
               state_in      = ST_RESP;
            end else if (status.op_valid && status.path_ok) begin
               cmd.stats_rd = 1'b1;
               state_in     = ST_READ;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            cmd.latch_entry = 1'b1;
            state_in = (status.op == OP_RECORD) ? ST_UPDATE : ST_QSTART;
         end
         ST_UPDATE: begin
            cmd.do_update = 1'b1;
            state_in      = ST_RESP;
         end
         ST_QSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_FLAGS;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FLAGS: begin
            cmd.flags_calc = 1'b1;
            state_in       = ST_RANK;
         end
         ST_RANK: begin
            cmd.rank_calc = 1'b1;
            if (status.rank_last) begin
               state_in = status.fill_zero ? ST_RESP : ST_CAND_RD;
            end
         end
         ST_CAND_RD: begin
            cmd.cand_rd = 1'b1;
            state_in    = ST_CAND_LATCH;
         end
         ST_CAND_LATCH: begin
            cmd.cand_latch = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_EVAL;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.cand_last ? ST_RESP : ST_CAND_RD;
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> out_free)
      else $error("result loaded over an untaken result");
   a_take_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.take_item |=> state_ff == ST_DECODE)
      else $error("accepted item not decoded");
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside response state");
endmodule

>>> sv/lsm_dp.sv
// lsm_dp: statistics table, sample store, divider and percentile selection
// depends on lsm_pkg and lsm_ram; controlled by lsm_ctrl
`timescale 1ns / 1ps
module lsm_dp import lsm_pkg::*; #(
   parameter int PATH_COUNT   = DEF_PATH_COUNT,
   parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  lsm_cmd_type    cmd,
   output lsm_status_type status,
   input  lsm_req_type    req_data,
   input  lsm_cfg_type    cfg,
   output lsm_rsp_type    rsp_data
);
   localparam int PATH_W  = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;
   localparam int FILL_W  = $clog2(SAMPLE_DEPTH + 1);
   localparam int SADDR_W = (PATH_COUNT * SAMPLE_DEPTH > 1) ?
                            $clog2(PATH_COUNT * SAMPLE_DEPTH) : 1;
   localparam int ENTRY_W = $bits(lsm_entry_type) + FILL_W;
   localparam lsm_entry_type EMPTY_ENTRY = '{calls: '0, total: '0,
                                             shortest: '1, longest: '0};

   lsm_req_type         item_ff;
   lsm_entry_type       ent_ff, ent_in, ent_rd;
   logic [FILL_W-1:0]   fill_ff, fill_in, fill_rd;
   logic [PATH_COUNT-1:0] valid_ff;
   logic [PATH_W-1:0]   path_ix;
   logic [ENTRY_W-1:0]  stats_rdata;
   logic [31:0]         samp_rdata;
   logic [SADDR_W-1:0]  path_base, samp_wr_addr, samp_rd_addr;
   logic                samp_wr, samp_rd;

   // divider and query registers
   logic [32:0]         rem_ff;
   logic [47:0]         quo_ff;
   logic [5:0]          dcnt_ff;
   logic [31:0]         mean_ff;
   logic [2:0]          flags_ff;
   logic [1:0]          k_ff;
   logic [FILL_W-1:0]   rank_ff [3];
   logic [31:0]         pct_ff [3];
   logic [FILL_W-1:0]   i_ff, j_ff, lt_ff, le_ff;
   logic [31:0]         cand_ff;
   logic                pend_ff;

   logic [31:0]         calls_sat;
   logic [48:0]         tot_sum;
   logic [6:0]          limit_eff;
   logic                store;
   logic [32:0]         shifted;
   logic [33:0]         diff;
   logic [31:0]         mean_sat, range_ns;
   logic [35:0]         mean_x10;
   logic                seen;
   logic                scan_issue;
   lsm_rsp_type         rsp_ff, rsp_in;

   assign path_ix   = PATH_W'(item_ff.path_index);
   assign path_base = SADDR_W'(path_ix * SAMPLE_DEPTH);

   assign status.op        = lsm_op_type'(item_ff.opcode);
   assign status.op_valid  = (item_ff.opcode == OP_RECORD) ||
                             (item_ff.opcode == OP_QUERY) ||
                             (item_ff.opcode == OP_CLEAR);
   assign status.path_ok   = 9'(item_ff.path_index) < 9'(PATH_COUNT);
   assign status.div_done  = (dcnt_ff == '0);
   assign status.rank_last = (k_ff == 2'd2);
   assign status.fill_zero = (fill_ff == '0);
   assign status.scan_done = (j_ff == fill_ff) && !pend_ff;
   assign status.cand_last = (i_ff == fill_ff - FILL_W'(1));

   lsm_ram #(.WIDTH(ENTRY_W), .DEPTH(PATH_COUNT)) u_stats_ram (
      .clock   (clock),
      .wr_en   (cmd.do_update),
      .wr_addr (path_ix),
      .wr_data ({ent_in, fill_in}),
      .rd_en   (cmd.stats_rd),
      .rd_addr (path_ix),
      .rd_data (stats_rdata)
   );

   lsm_ram #(.WIDTH(32), .DEPTH(PATH_COUNT * SAMPLE_DEPTH)) u_sample_ram (
      .clock   (clock),
      .wr_en   (samp_wr),
      .wr_addr (samp_wr_addr),
      .wr_data (item_ff.elapsed_ns),
      .rd_en   (samp_rd),
      .rd_addr (samp_rd_addr),
      .rd_data (samp_rdata)
   );

   // an entry never written since clear reads as the empty entry
   always_comb begin
      if (valid_ff[path_ix]) begin
         ent_rd  = stats_rdata[ENTRY_W-1:FILL_W];
         fill_rd = stats_rdata[FILL_W-1:0];
      end else begin
         ent_rd  = EMPTY_ENTRY;
         fill_rd = '0;
      end
   end

   // record update
   always_comb begin
      calls_sat = (ent_ff.calls == '1) ? ent_ff.calls : ent_ff.calls + 32'd1;
      tot_sum   = {1'b0, ent_ff.total} + 49'(item_ff.elapsed_ns);
      limit_eff = (12'(cfg.sample_limit) > 12'(SAMPLE_DEPTH)) ?
                  7'(SAMPLE_DEPTH) : cfg.sample_limit;
      store     = cfg.sampling_enable && (12'(fill_ff) < 12'(limit_eff));
      ent_in.calls    = calls_sat;
      ent_in.total    = tot_sum[48] ? '1 : tot_sum[47:0];
      ent_in.shortest = (item_ff.elapsed_ns < ent_ff.shortest) ?
                        item_ff.elapsed_ns : ent_ff.shortest;
      ent_in.longest  = (item_ff.elapsed_ns > ent_ff.longest) ?
                        item_ff.elapsed_ns : ent_ff.longest;
      fill_in = fill_ff + FILL_W'(store);
   end

   assign samp_wr      = cmd.do_update && store;
   assign samp_wr_addr = path_base + SADDR_W'(fill_ff);
   assign scan_issue   = cmd.scan_rd && (j_ff != fill_ff);
   assign samp_rd      = cmd.cand_rd || scan_issue;
   assign samp_rd_addr = path_base + SADDR_W'(cmd.cand_rd ? i_ff : j_ff);

   // restoring divide step and query arithmetic
   always_comb begin
      shifted  = {rem_ff[31:0], quo_ff[47]};
      diff     = {1'b0, shifted} - {2'b0, ent_ff.calls};
      seen     = (ent_ff.calls != '0);
      mean_sat = !seen ? '0 : ((quo_ff[47:32] != '0) ? '1 : quo_ff[31:0]);
      range_ns = ent_ff.longest - ent_ff.shortest;
      mean_x10 = {1'b0, mean_sat, 3'b0} + {3'b0, mean_sat, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pend_ff  <= 1'b0;
         dcnt_ff  <= '0;
      end else begin
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else if (cmd.do_update) begin
            valid_ff[path_ix] <= 1'b1;
         end
         pend_ff <= scan_issue;
         if (cmd.div_start) begin
            dcnt_ff <= 6'(DIV_STEPS);
         end else if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_ff <= req_data;
      end
      if (cmd.latch_entry) begin
         ent_ff  <= ent_rd;
         fill_ff <= fill_rd;
      end else if (cmd.do_update) begin
         ent_ff  <= ent_in;
         fill_ff <= fill_in;
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= ent_ff.total;
         k_ff   <= '0;
         i_ff   <= '0;
         for (int p = 0; p < 3; p++) begin
            pct_ff[p] <= '0;
         end
      end
      if (cmd.div_step) begin
         if (!diff[33]) begin
            rem_ff <= diff[32:0];
         end else begin
            rem_ff <= shifted;
         end
         quo_ff <= {quo_ff[46:0], ~diff[33]};
      end
      if (cmd.flags_calc) begin
         mean_ff     <= mean_sat;
         flags_ff[0] <= seen && (36'(range_ns) > mean_x10);
         flags_ff[1] <= seen && (mean_sat > cfg.slow_average_ns);
         flags_ff[2] <= ent_ff.calls > cfg.hot_call_count;
      end
      if (cmd.rank_calc) begin
         rank_ff[k_ff] <= FILL_W'(rank_of(PCT_POINT[k_ff], RANK_N_W'(fill_ff)));
         k_ff          <= k_ff + 2'd1;
      end
      if (cmd.cand_latch) begin
         cand_ff <= samp_rdata;
         lt_ff   <= '0;
         le_ff   <= '0;
         j_ff    <= '0;
      end
      if (scan_issue) begin
         j_ff <= j_ff + FILL_W'(1);
      end
      if (pend_ff) begin
         // rank of candidate: count of smaller and of not larger samples
         lt_ff <= lt_ff + FILL_W'(samp_rdata < cand_ff);
         le_ff <= le_ff + FILL_W'(samp_rdata <= cand_ff);
      end
      if (cmd.eval) begin
         for (int p = 0; p < 3; p++) begin
            if (lt_ff <= rank_ff[p] && rank_ff[p] < le_ff) begin
               pct_ff[p] <= cand_ff;
            end
         end
         i_ff <= i_ff + FILL_W'(1);
      end
      if (cmd.load_result) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (status.path_ok && (item_ff.opcode == OP_RECORD ||
                             item_ff.opcode == OP_QUERY)) begin
         rsp_in.path_seen    = seen;
         rsp_in.calls        = ent_ff.calls;
         rsp_in.total_ns     = ent_ff.total;
         rsp_in.shortest_ns  = seen ? ent_ff.shortest : '0;
         rsp_in.longest_ns   = seen ? ent_ff.longest : '0;
         rsp_in.samples_held = 7'(fill_ff);
         if (item_ff.opcode == OP_QUERY) begin
            rsp_in.mean_ns       = mean_ff;
            rsp_in.median_ns     = pct_ff[0];
            rsp_in.p95_ns        = pct_ff[1];
            rsp_in.p99_ns        = pct_ff[2];
            rsp_in.insight_flags = flags_ff;
         end
      end
   end

   assign rsp_data = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.do_update) |-> 12'(fill_ff) <= 12'(SAMPLE_DEPTH))
      else $error("sample fill beyond store depth");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |-> j_ff <= fill_ff)
      else $error("scan index beyond fill");
   a_pend_src: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd.scan_rd))
      else $error("compare without a scan read");
endmodule

>>> sv/latency_statistics_monitor.sv
// latency_statistics_monitor: top level with register file, controller and datapath
// depends on lsm_pkg, lsm_ctrl, lsm_dp
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (lsm_req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (lsm_rsp_type)
//   csr      in/out     psel/penable/pready    paddr, pwdata, pwrite, prdata
//
// clear, unused opcode or unknown path: decode, then response; record: decode, read, update, response
// query: each of the n stored samples is compared with all n stored samples in turn,
// itself included, through the single read port of the sample ram, after the
// one-bit-per-cycle divider has formed the mean
// one item at a time; a new item is taken while a result waits on rsp
// a stalled rsp holds the next result in the response state
// synchronous reset clears all paths and restores register defaults
`timescale 1ns / 1ps
module latency_statistics_monitor import lsm_pkg::*; #(
   parameter int PATH_COUNT   = DEF_PATH_COUNT,
   parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lsm_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lsm_rsp_type        rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   lsm_cfg_type    cfg_ff;
   lsm_cmd_type    cmd;
   lsm_status_type status;
   lsm_reg_type    reg_sel;
   logic           wr_en;

   assign reg_sel = lsm_reg_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sampling_enable <= RESET_SAMPLING;
         cfg_ff.sample_limit    <= RESET_LIMIT;
         cfg_ff.slow_average_ns <= RESET_SLOW;
         cfg_ff.hot_call_count  <= RESET_HOT;
      end else if (wr_en) begin
         case (reg_sel)
            REG_SAMPLING: cfg_ff.sampling_enable <= pwdata[0];
            REG_LIMIT:    cfg_ff.sample_limit    <= pwdata[6:0];
            REG_SLOW:     cfg_ff.slow_average_ns <= pwdata;
            REG_HOT:      cfg_ff.hot_call_count  <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SAMPLING: prdata = {31'b0, cfg_ff.sampling_enable};
         REG_LIMIT:    prdata = {25'b0, cfg_ff.sample_limit};
         REG_SLOW:     prdata = cfg_ff.slow_average_ns;
         REG_HOT:      prdata = cfg_ff.hot_call_count;
         default:      prdata = '0;
      endcase
   end

   lsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsm_dp #(.PATH_COUNT(PATH_COUNT), .SAMPLE_DEPTH(SAMPLE_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .rsp_data (rsp_data)
   );
endmodule
